/* rtl/core/stb_pkg.sv */
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int TIMER_SLOTS_DEF = 8;
  localparam int CNT_W           = 16;
  localparam int IDX_W           = 8;

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_SNAP  = 3'd1,
    MODE_CHECK = 3'd2,
    MODE_CSNAP = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  // outcome of one item, from the execute unit to the top level
  typedef struct packed {
    logic             timed_out;
    logic             wr_en;
    logic [CNT_W-1:0] cnt_nxt;
  } exec_res_t;

endpackage

/* rtl/core/stb_ram.sv */
// ----------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module stb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/stb_exec.sv */
// ----------------------------------------------------------------------------
// stb_exec
// Per-item execute logic: counter update, timeout compare and write decision.
// ----------------------------------------------------------------------------
module stb_exec (
  input  stb_pkg::mode_t                 mode,
  input  logic                           in_range,
  input  logic [stb_pkg::CNT_W-1:0]      slot_val,
  input  logic [stb_pkg::CNT_W-1:0]      interval,
  input  logic [stb_pkg::CNT_W-1:0]      tick_cnt,
  output stb_pkg::exec_res_t             res
);

  logic [stb_pkg::CNT_W-1:0] due;
  logic                      elapsed;

  // sum wraps modulo 2^16 before the compare
  assign due     = slot_val + interval;
  assign elapsed = in_range && (due <= tick_cnt);

  always_comb begin
    res.timed_out = 1'b0;
    res.wr_en     = 1'b0;
    res.cnt_nxt   = tick_cnt;
    case (mode)
      stb_pkg::MODE_TICK: begin
        res.cnt_nxt = tick_cnt + stb_pkg::CNT_W'(1);
      end
      stb_pkg::MODE_SNAP: begin
        res.wr_en = in_range;
      end
      stb_pkg::MODE_CHECK: begin
        res.timed_out = elapsed;
      end
      stb_pkg::MODE_CSNAP: begin
        res.timed_out = elapsed;
        res.wr_en     = elapsed;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/software_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// software_timer_bank_unit
// A bank of TIMER_SLOTS software timers sharing one wrapping 16-bit tick
// counter. Each item ticks the counter, snaps it into a slot, checks whether
// slot + interval (mod 2^16) <= counter, checks and re-snaps on a timeout, or
// reads the counter, and returns one item holding the flag and the updated
// counter. Slots sit in a synchronous RAM; each item reads its slot and a snap
// then writes the counter into it, and a new item is taken once the previous
// one has left the execute stage. A finished result waits in the output
// register without holding up the next item's RAM read. Slots read as zero
// after reset through per-slot valid flops, so no clearing pass.
// ----------------------------------------------------------------------------
module software_timer_bank_unit #(
  parameter int TIMER_SLOTS = stb_pkg::TIMER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // timer_index[7:0], interval[23:8]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // timed_out[0], tick_value[16:1], zero[23:17]
);

  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = stb_pkg::CNT_W;
  localparam logic [stb_pkg::IDX_W:0] SLOTS_V = (stb_pkg::IDX_W + 1)'(TIMER_SLOTS);

  logic                     in_fire;
  logic                     s1_fire;
  logic [stb_pkg::IDX_W-1:0] idx;
  logic                     idx_ok;

  logic                     s1_valid_r;
  stb_pkg::mode_t           s1_mode_r;
  logic [AW-1:0]            s1_addr_r;
  logic                     s1_in_range_r;
  logic                     s1_slot_vld_r;
  logic [CW-1:0]            s1_interval_r;

  logic [TIMER_SLOTS-1:0]   slot_vld_r;
  logic [TIMER_SLOTS-1:0]   slot_vld_nxt;
  logic [CW-1:0]            tick_cnt_r;
  logic                     out_valid_r;
  logic [23:0]              out_data_r;

  logic [CW-1:0]            rdata;
  logic [CW-1:0]            slot_val;
  stb_pkg::exec_res_t       res;
  logic                     mem_we;

  assign idx       = in_tdata[7:0];
  assign idx_ok    = {1'b0, idx} < SLOTS_V;
  assign in_tready = !s1_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);

  stb_ram #(
    .WIDTH(CW),
    .DEPTH(TIMER_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(s1_addr_r),
    .wdata(tick_cnt_r),
    .re   (in_fire),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  // a slot never written since reset reads as zero
  assign slot_val = s1_slot_vld_r ? rdata : '0;

  stb_exec u_exec (
    .mode    (s1_mode_r),
    .in_range(s1_in_range_r),
    .slot_val(slot_val),
    .interval(s1_interval_r),
    .tick_cnt(tick_cnt_r),
    .res     (res)
  );

  assign mem_we = s1_fire && res.wr_en;

  always_comb begin
    slot_vld_nxt = slot_vld_r;
    if (mem_we) begin
      slot_vld_nxt[s1_addr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      slot_vld_r  <= '0;
      tick_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_vld_r <= slot_vld_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        tick_cnt_r  <= res.cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r     <= stb_pkg::mode_t'(in_tuser);
      s1_addr_r     <= idx[AW-1:0];
      s1_in_range_r <= idx_ok;
      s1_slot_vld_r <= slot_vld_r[idx[AW-1:0]];
      s1_interval_r <= in_tdata[23:8];
    end
    if (s1_fire) begin
      out_data_r <= {7'd0, res.cnt_nxt, res.timed_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_mode_r == stb_pkg::MODE_TICK)
      |=> tick_cnt_r == $past(tick_cnt_r) + CW'(1))
    else $error("tick item did not advance the counter");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (s1_in_range_r
      && (s1_mode_r == stb_pkg::MODE_SNAP || s1_mode_r == stb_pkg::MODE_CSNAP)))
    else $error("slot write outside a snap item or outside the table");

  a_flag_check_only: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res.timed_out)
      |-> (s1_mode_r == stb_pkg::MODE_CHECK || s1_mode_r == stb_pkg::MODE_CSNAP))
    else $error("timeout flag raised by a non-check item");

  a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> s1_valid_r && $stable(s1_addr_r))
    else $error("stalled item lost in the execute stage");

endmodule

/* tb/tb_software_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// tb_software_timer_bank_unit
// Self-checking testbench for the software timer bank. A queue of items
// (tick, snap, check, check-and-snap, read, spare modes) feeds a stream
// driver; every accepted item updates a local copy of the counter and slot
// table, and the predicted flag and counter are matched in order against the
// result stream. Sender and receiver idle at random, with long receiver
// hold-offs and a sender pause that drains the block between phases.
// ----------------------------------------------------------------------------
module tb_software_timer_bank_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = stb_pkg::TIMER_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_LEN    = 400;
  localparam int PHASE_ITEMS = 640;

  // mode codes the block does not define; they must act as a read
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  idx;
    logic [15:0] interval;
  } timer_item_t;

  typedef struct packed {
    logic        timed_out;
    logic [15:0] tick_value;
  } bank_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // timer_index[7:0], interval[23:8]
  logic [2:0]  in_tuser = '0;   // mode[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // timed_out[0], tick_value[16:1], zero[23:17]

  timer_item_t  pending_items[$];
  bank_result_t expected_results[$];

  // local copy of the timer bank state
  logic [15:0] tick_count;
  logic [15:0] slot_snap[SLOTS];

  int send_idle_pct = 24;
  int recv_idle_pct = 69;
  int items_queued  = 0;
  int items_taken   = 0;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;

  software_timer_bank_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bank_result_t timer_bank_step(logic [2:0] mode, logic [7:0] idx,
                                                   logic [15:0] interval);
    bank_result_t r;
    logic         in_range;
    logic         elapsed;
    logic [15:0]  due;
    r        = '0;
    in_range = (idx < SLOTS);
    elapsed  = 1'b0;
    if (in_range) begin
      // sum wraps at 16 bits before the compare
      due     = slot_snap[idx] + interval;
      elapsed = (due <= tick_count);
    end
    case (mode)
      stb_pkg::MODE_TICK: tick_count = tick_count + 16'd1;
      stb_pkg::MODE_SNAP: if (in_range) slot_snap[idx] = tick_count;
      stb_pkg::MODE_CHECK: r.timed_out = elapsed;
      stb_pkg::MODE_CSNAP: begin
        r.timed_out = elapsed;
        if (elapsed) slot_snap[idx] = tick_count;
      end
      default: ;
    endcase
    r.tick_value = tick_count;
    return r;
  endfunction

  task automatic push_item(logic [2:0] mode, logic [7:0] idx, logic [15:0] interval);
    timer_item_t it;
    it.mode     = mode;
    it.idx      = idx;
    it.interval = interval;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic timer_item_t random_item();
    timer_item_t it;
    int          pick;
    pick = int'($urandom_range(99));
    if (pick < 30)      it.mode = stb_pkg::MODE_TICK;
    else if (pick < 45) it.mode = stb_pkg::MODE_SNAP;
    else if (pick < 70) it.mode = stb_pkg::MODE_CHECK;
    else if (pick < 90) it.mode = stb_pkg::MODE_CSNAP;
    else if (pick < 97) it.mode = stb_pkg::MODE_READ;
    else begin
      case ($urandom_range(2))
        0: it.mode = MODE_SPARE5;
        1: it.mode = MODE_SPARE6;
        default: it.mode = MODE_SPARE7;
      endcase
    end
    if (SLOTS < 256 && $urandom_range(99) < 15) it.idx = 8'($urandom_range(255, SLOTS));
    else it.idx = 8'($urandom_range(SLOTS - 1));
    // mostly short intervals so checks land on both sides of the counter
    pick = int'($urandom_range(99));
    if (pick < 60)      it.interval = 16'($urandom_range(48));
    else if (pick < 85) it.interval = 16'($urandom_range(16'hffff));
    else it.interval = 16'($urandom_range(16'hffff, 16'hffff - 48));
    return it;
  endfunction

  task automatic wait_all_done();
    while (items_taken != items_queued || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      pending_items.push_back(random_item());
      items_queued++;
    end
    wait_all_done();
  endtask

  initial begin
    tick_count = '0;
    foreach (slot_snap[k]) slot_snap[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset contents, extremes, out-of-range slots, spare modes
    push_item(stb_pkg::MODE_READ,  8'd0,   16'd0);
    push_item(stb_pkg::MODE_CHECK, 8'd0,   16'd0);
    push_item(stb_pkg::MODE_CHECK, 8'd7,   16'hffff);
    push_item(stb_pkg::MODE_CSNAP, 8'd0,   16'd0);
    push_item(stb_pkg::MODE_TICK,  8'd255, 16'hffff);
    push_item(stb_pkg::MODE_TICK,  8'd0,   16'd0);
    push_item(stb_pkg::MODE_SNAP,  8'd3,   16'd0);
    push_item(stb_pkg::MODE_CHECK, 8'd3,   16'd1);
    push_item(stb_pkg::MODE_TICK,  8'd0,   16'd0);
    push_item(stb_pkg::MODE_CHECK, 8'd3,   16'd1);
    push_item(stb_pkg::MODE_CSNAP, 8'd3,   16'd1);
    push_item(stb_pkg::MODE_CHECK, 8'd3,   16'd0);
    push_item(stb_pkg::MODE_CSNAP, 8'd3,   16'd1);
    push_item(stb_pkg::MODE_SNAP,  8'd8,   16'd0);
    push_item(stb_pkg::MODE_CHECK, 8'd8,   16'd0);
    push_item(stb_pkg::MODE_CHECK, 8'd255, 16'd0);
    push_item(stb_pkg::MODE_CSNAP, 8'd200, 16'd0);
    push_item(MODE_SPARE5, 8'd255, 16'hffff);
    push_item(MODE_SPARE6, 8'd1,   16'h8000);
    push_item(MODE_SPARE7, 8'd128, 16'h0001);
    push_item(stb_pkg::MODE_CHECK, 8'd1,   16'hffff);
    push_item(stb_pkg::MODE_SNAP,  8'd1,   16'd0);
    // slot 1 + 0xfffe wraps below the counter and reports early
    push_item(stb_pkg::MODE_CHECK, 8'd1,   16'hfffe);
    push_item(stb_pkg::MODE_CSNAP, 8'd7,   16'hffff);
    push_item(stb_pkg::MODE_READ,  8'd255, 16'hffff);
    wait_all_done();

    run_random(PHASE_ITEMS);
    send_idle_pct = 69;
    recv_idle_pct = 24;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    timer_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {it.interval, it.idx};
        in_tuser  <= it.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with long hold-offs to fill the block
  int results_seen = 0;
  int hold_left    = 0;
  int last_hold_at = -1;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) results_seen++;
      if ((results_seen == 1000 || results_seen == 1700) && results_seen != last_hold_at) begin
        hold_left    = HOLD_LEN;
        last_hold_at = results_seen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    bank_result_t want;
    if (rst_n) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(timer_bank_step(in_tuser, in_tdata[7:0], in_tdata[23:8]));
        items_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no item pending: tdata %h", out_tdata);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[0] !== want.timed_out) begin
            $error("timed_out: expected %0d, got %0d", want.timed_out, out_tdata[0]);
            fail_cnt++;
          end
          if (out_tdata[16:1] !== want.tick_value) begin
            $error("tick_value: expected %0d, got %0d", want.tick_value, out_tdata[16:1]);
            fail_cnt++;
          end
          if (out_tdata[23:17] !== '0) begin
            $error("pad: expected 0, got %h", out_tdata[23:17]);
            fail_cnt++;
          end
        end
      end
    end
  end

endmodule
